// ===== hw/rtl/edd_pkg.sv =====
// Shared types and constants for the edit distance engine.
// Used by edd_ram and edit_distance_engine_top; depends on nothing.
package edd_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int ACT_W       = 2;
    localparam int DIST_W      = 7;

    // Action codes carried in the input word
    localparam logic [ACT_W-1:0] ACT_PATTERN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TEXT    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SYM_W-1:0] symbol;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_CELL_RD,
        ST_CELL_CALC,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/edd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on edd_pkg for default sizes only.
module edd_ram #(
    parameter int WIDTH = edd_pkg::SYM_W,
    parameter int DEPTH = edd_pkg::MAX_LEN_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/edit_distance_engine_top.sv =====
// Levenshtein edit distance engine, top level. Uses edd_pkg and edd_ram.
// Append words are accepted back to back while idle. A compute word holds the input
// stalled until its result is loaded into the output register. Each table cell takes
// a read state (ST_CELL_RD) and a compute state (ST_CELL_CALC), using one
// row-buffer RAM and one shared min-of-three unit.
// Reset (synchronous, active low) clears lengths, drop flag, loop indices, state and output valid.
module edit_distance_engine_top #(
    parameter int MAX_LEN = edd_pkg::MAX_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  edd_pkg::t_in_word i_in_word,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output edd_pkg::t_out_word o_out_word,
    input  logic              i_out_stall
);

    // LW holds a length 0..MAX_LEN and also addresses the row buffer (MAX_LEN+1 deep)
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = LW + 1;
    localparam int DW = edd_pkg::DIST_W;
    localparam int BW = edd_pkg::SYM_W;

    // Control registers
    edd_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_pat_len, n_pat_len;
    logic [LW-1:0]   r_txt_len, n_txt_len;
    logic            r_dropped, n_dropped;
    logic [LW-1:0]   r_i, n_i;
    logic [LW-1:0]   r_j, n_j;
    logic            r_out_valid, n_out_valid;

    // Datapath registers
    logic [BW-1:0]      r_pc, n_pc;
    logic [LW-1:0]      r_diag, n_diag;
    logic [LW-1:0]      r_left, n_left;
    edd_pkg::t_out_word r_out_word, n_out_word;

    // RAM ports
    logic          pat_we, txt_we, row_we;
    logic [AW-1:0] pat_ra, txt_ra;
    logic [LW-1:0] row_wa, row_ra, row_wd, row_rd;
    logic [BW-1:0] pat_rd, txt_rd;

    // Shared cell unit: min of above+1, left+1, diag+cost
    logic [SW-1:0] up_sum, left_sum, diag_sum, min_ab, min_abc;
    logic          cost;

    edd_ram #(.WIDTH(BW), .DEPTH(MAX_LEN)) u_pat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pat_we),
        .i_wr_addr (AW'(r_pat_len)),
        .i_wr_data (i_in_word.symbol),
        .i_rd_addr (pat_ra),
        .o_rd_data (pat_rd)
    );

    edd_ram #(.WIDTH(BW), .DEPTH(MAX_LEN)) u_txt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (txt_we),
        .i_wr_addr (AW'(r_txt_len)),
        .i_wr_data (i_in_word.symbol),
        .i_rd_addr (txt_ra),
        .o_rd_data (txt_rd)
    );

    edd_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_we),
        .i_wr_addr (row_wa),
        .i_wr_data (row_wd),
        .i_rd_addr (row_ra),
        .o_rd_data (row_rd)
    );

    // Read addresses matter only in the read states; drive them freely otherwise
    assign pat_ra = AW'(r_i - LW'(1));
    assign txt_ra = AW'(r_j - LW'(1));
    assign row_ra = (r_state == edd_pkg::ST_ROW_RD) ? '0 : r_j;

    assign cost     = (r_pc != txt_rd);
    assign up_sum   = SW'(row_rd) + SW'(1);
    assign left_sum = SW'(r_left) + SW'(1);
    assign diag_sum = SW'(r_diag) + SW'(cost);
    assign min_ab   = (up_sum < left_sum) ? up_sum : left_sum;
    assign min_abc  = (min_ab < diag_sum) ? min_ab : diag_sum;

    // Take input words only while idle; a finished result may still be waiting
    assign o_in_stall  = (r_state != edd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_pat_len   = r_pat_len;
        n_txt_len   = r_txt_len;
        n_dropped   = r_dropped;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        n_pc        = r_pc;
        n_diag      = r_diag;
        n_left      = r_left;
        n_out_word  = r_out_word;
        pat_we      = 1'b0;
        txt_we      = 1'b0;
        row_we      = 1'b0;
        row_wa      = r_j;
        row_wd      = r_j;

        // Drop the output word once the sink takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            edd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_word.action)
                        edd_pkg::ACT_PATTERN: begin
                            // Append, or drop the byte and flag it when full
                            if (r_pat_len < LW'(MAX_LEN)) begin
                                pat_we    = 1'b1;
                                n_pat_len = r_pat_len + LW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        edd_pkg::ACT_TEXT: begin
                            if (r_txt_len < LW'(MAX_LEN)) begin
                                txt_we    = 1'b1;
                                n_txt_len = r_txt_len + LW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        edd_pkg::ACT_COMPUTE: begin
                            n_j     = '0;
                            n_state = edd_pkg::ST_INIT;
                        end
                        default: begin
                            // Unused action: no result, no state change
                        end
                    endcase
                end
            end

            edd_pkg::ST_INIT: begin
                // Seed row zero of the table: row[j] = j
                row_we = 1'b1;
                row_wa = r_j;
                row_wd = r_j;
                n_left = r_j;
                if (r_j == r_txt_len) begin
                    if (r_pat_len == '0) begin
                        n_state = edd_pkg::ST_DONE;
                    end else begin
                        n_i     = LW'(1);
                        n_state = edd_pkg::ST_ROW_RD;
                    end
                end else begin
                    n_j = r_j + LW'(1);
                end
            end

            edd_pkg::ST_ROW_RD: begin
                // Pattern byte i-1 and row[0] come back next cycle
                n_state = edd_pkg::ST_ROW_LD;
            end

            edd_pkg::ST_ROW_LD: begin
                n_pc   = pat_rd;
                n_diag = row_rd;
                row_we = 1'b1;
                row_wa = '0;
                row_wd = r_i;
                n_left = r_i;
                n_j    = LW'(1);
                if (r_txt_len == '0) begin
                    if (r_i == r_pat_len) begin
                        n_state = edd_pkg::ST_DONE;
                    end else begin
                        n_i     = r_i + LW'(1);
                        n_state = edd_pkg::ST_ROW_RD;
                    end
                end else begin
                    n_state = edd_pkg::ST_CELL_RD;
                end
            end

            edd_pkg::ST_CELL_RD: begin
                // Text byte j-1 and row[j] (the cell above) come back next cycle
                n_state = edd_pkg::ST_CELL_CALC;
            end

            edd_pkg::ST_CELL_CALC: begin
                // Values never exceed MAX_LEN, so the narrowing is lossless
                row_we = 1'b1;
                row_wa = r_j;
                row_wd = LW'(min_abc);
                n_left = LW'(min_abc);
                n_diag = row_rd;
                if (r_j == r_txt_len) begin
                    if (r_i == r_pat_len) begin
                        n_state = edd_pkg::ST_DONE;
                    end else begin
                        n_i     = r_i + LW'(1);
                        n_state = edd_pkg::ST_ROW_RD;
                    end
                end else begin
                    n_j     = r_j + LW'(1);
                    n_state = edd_pkg::ST_CELL_RD;
                end
            end

            edd_pkg::ST_DONE: begin
                // Hold until the output register is free, then load it and clear
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out_word.distance = DW'(r_left);
                    n_out_word.overflow = r_dropped;
                    n_pat_len           = '0;
                    n_txt_len           = '0;
                    n_dropped           = 1'b0;
                    n_state             = edd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = edd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edd_pkg::ST_IDLE;
            r_pat_len   <= '0;
            r_txt_len   <= '0;
            r_dropped   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pat_len   <= n_pat_len;
            r_txt_len   <= n_txt_len;
            r_dropped   <= n_dropped;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc       <= n_pc;
        r_diag     <= n_diag;
        r_left     <= n_left;
        r_out_word <= n_out_word;
    end

    // Lengths never pass the store depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pat_len <= LW'(MAX_LEN)) && (r_txt_len <= LW'(MAX_LEN)))
        else $error("string length beyond store depth");

    // A table cell always lies inside the loaded strings
    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edd_pkg::ST_CELL_CALC) |->
            (r_j != '0) && (r_j <= r_txt_len) && (r_i != '0) && (r_i <= r_pat_len))
        else $error("cell index outside table");

    // Handing off a result presents it and clears lengths and flag
    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edd_pkg::ST_DONE && (!r_out_valid || !i_out_stall)) |=>
            (r_out_valid && r_pat_len == '0 && r_txt_len == '0 && !r_dropped &&
             r_state == edd_pkg::ST_IDLE))
        else $error("result handoff did not clear state");

    // Only a compute word leaves idle
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == edd_pkg::ST_IDLE && n_state != edd_pkg::ST_IDLE) |->
            (i_in_valid && i_in_word.action == edd_pkg::ACT_COMPUTE))
        else $error("left idle without compute word");

endmodule
